FILE: design/jaec_pkg.sv
// Shared types, constants and character codes for the JSON array element counter.
package jaec_pkg;

	localparam int MAX_DEPTH   = 255;
	localparam int COUNT_WIDTH = 16;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
	localparam int OUT_COUNT_W = 16;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;

	typedef enum logic [3:0] {
		PH_AWAIT = 4'b0001,
		PH_AFTER = 4'b0010,
		PH_SCAN  = 4'b0100,
		PH_DRAIN = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NOT_ARRAY    = 2'd1,
		ST_UNTERMINATED = 2'd2,
		ST_TOO_DEEP     = 2'd3
	} status_t;

	typedef struct packed {
		phase_t                   phase;
		logic [DEPTH_W-1:0]       depth;
		logic                     in_str;
		logic                     esc;
		logic                     seen;
		logic [COUNT_WIDTH-1:0]   count;
	} scan_state_t;

	typedef struct packed {
		logic                     valid;
		status_t                  status;
		logic [OUT_COUNT_W-1:0]   count;
	} scan_result_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:  PH_AWAIT,
		depth:  '0,
		in_str: 1'b0,
		esc:    1'b0,
		seen:   1'b0,
		count:  '0
	};

	function automatic logic is_blank(input logic [7:0] c);
		is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Zero-extend or truncate the running count to the result field width.
	function automatic logic [OUT_COUNT_W-1:0] fold_count(input logic [COUNT_WIDTH-1:0] cnt);
		logic [31:0] wide;
		wide = 32'(cnt);
		fold_count = wide[OUT_COUNT_W-1:0];
	endfunction

endpackage

FILE: design/jaec_if.sv
// Valid/ready channel interfaces for text bytes in and count results out.
interface jaec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface jaec_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] element_count;

	modport source(output valid, output status, output element_count, input ready);
	modport sink(input valid, input status, input element_count, output ready);
endinterface

FILE: design/jaec_step.sv
// Per-byte next-state and result logic of the array scanner.
module jaec_step (
	input  logic [7:0]            text_byte,
	input  jaec_pkg::scan_state_t cur,
	output jaec_pkg::scan_state_t nxt,
	output jaec_pkg::scan_result_t res
);

	logic                            blank;
	logic [jaec_pkg::COUNT_WIDTH-1:0] bumped;

	assign blank  = jaec_pkg::is_blank(text_byte);
	// saturating increment
	assign bumped = (&cur.count) ? cur.count : cur.count + 1'b1;

	always_comb begin
		nxt        = cur;
		res.valid  = 1'b0;
		res.status = jaec_pkg::ST_OK;
		res.count  = '0;
		case (cur.phase)
			jaec_pkg::PH_DRAIN: begin
				if (text_byte == jaec_pkg::CH_NUL) begin
					nxt = jaec_pkg::SCAN_RESET;
				end
			end
			jaec_pkg::PH_AWAIT: begin
				if (text_byte == jaec_pkg::CH_NUL) begin
					res.valid  = 1'b1;
					res.status = jaec_pkg::ST_NOT_ARRAY;
					nxt        = jaec_pkg::SCAN_RESET;
				end else if (blank) begin
					nxt = cur;
				end else if (text_byte != jaec_pkg::CH_LBRACKET) begin
					res.valid  = 1'b1;
					res.status = jaec_pkg::ST_NOT_ARRAY;
					nxt        = jaec_pkg::SCAN_RESET;
					nxt.phase  = jaec_pkg::PH_DRAIN;
				end else begin
					nxt.phase = jaec_pkg::PH_AFTER;
				end
			end
			jaec_pkg::PH_AFTER, jaec_pkg::PH_SCAN: begin
				if (text_byte == jaec_pkg::CH_NUL) begin
					res.valid  = 1'b1;
					res.status = jaec_pkg::ST_UNTERMINATED;
					nxt        = jaec_pkg::SCAN_RESET;
				end else if (cur.phase == jaec_pkg::PH_AFTER && blank) begin
					nxt = cur;
				end else if (cur.phase == jaec_pkg::PH_AFTER &&
						text_byte == jaec_pkg::CH_RBRACKET) begin
					// empty array
					res.valid = 1'b1;
					nxt       = jaec_pkg::SCAN_RESET;
					nxt.phase = jaec_pkg::PH_DRAIN;
				end else begin
					nxt.phase = jaec_pkg::PH_SCAN;
					if (cur.in_str) begin
						if (cur.esc) begin
							nxt.esc = 1'b0;
						end else if (text_byte == jaec_pkg::CH_BSLASH) begin
							nxt.esc = 1'b1;
						end else if (text_byte == jaec_pkg::CH_QUOTE) begin
							nxt.in_str = 1'b0;
						end
					end else if (blank) begin
						nxt.phase = jaec_pkg::PH_SCAN;
					end else if (text_byte == jaec_pkg::CH_QUOTE) begin
						nxt.in_str = 1'b1;
						nxt.seen   = 1'b1;
					end else if (text_byte == jaec_pkg::CH_LBRACE ||
							text_byte == jaec_pkg::CH_LBRACKET) begin
						if (cur.depth == jaec_pkg::DEPTH_W'(jaec_pkg::MAX_DEPTH)) begin
							res.valid  = 1'b1;
							res.status = jaec_pkg::ST_TOO_DEEP;
							nxt        = jaec_pkg::SCAN_RESET;
							nxt.phase  = jaec_pkg::PH_DRAIN;
						end else begin
							nxt.depth = cur.depth + 1'b1;
							nxt.seen  = 1'b1;
						end
					end else if (text_byte == jaec_pkg::CH_RBRACE ||
							text_byte == jaec_pkg::CH_RBRACKET) begin
						if (cur.depth != '0) begin
							nxt.depth = cur.depth - 1'b1;
						end else if (text_byte == jaec_pkg::CH_RBRACKET) begin
							res.valid = 1'b1;
							res.count = jaec_pkg::fold_count(cur.seen ? bumped : cur.count);
							nxt       = jaec_pkg::SCAN_RESET;
							nxt.phase = jaec_pkg::PH_DRAIN;
						end
					end else if (text_byte == jaec_pkg::CH_COMMA && cur.depth == '0) begin
						if (cur.seen) begin
							nxt.count = bumped;
							nxt.seen  = 1'b0;
						end
					end else begin
						nxt.seen = 1'b1;
					end
				end
			end
			default: begin
				nxt = jaec_pkg::SCAN_RESET;
			end
		endcase
	end

endmodule

FILE: design/json_array_element_counter_core.sv
// Top level of the JSON array element counter: input register, scanner state, result register.
// Counts the top-level elements of a JSON array fed one text byte per item; a zero byte ends
// the text. Throughput is one byte per cycle while no result waits untaken: each byte is
// captured in an input register and then, once the result register is free, the scanner state
// (phase, nesting depth, string/escape flags, element flag and saturating count) is updated by
// one short step of logic that also forms any result into the output register. A byte waits in
// the input register while a previous result is still held there. At most one result comes per
// text: status ok with the count at the closing bracket, or an error status with count zero for
// a text that does not open with a bracket, ends unterminated, or nests deeper than the depth
// limit. Bytes after a result are dropped until the zero byte. The result register frees the
// input side: a new byte is taken into an empty input register while a result still waits,
// and only the byte already in the input register is held until that result is taken.
module json_array_element_counter_core (
	input  logic            clk,
	input  logic            arst_n,
	jaec_in_if.sink         text,
	jaec_out_if.source      result
);

	// input register
	logic                    valid_s1;
	logic [7:0]              byte_s1;

	// scanner state
	jaec_pkg::scan_state_t   state_q;
	jaec_pkg::scan_state_t   state_nxt;
	jaec_pkg::scan_result_t  step_res;

	// result register
	logic                    out_valid_q;
	jaec_pkg::status_t       out_status_q;
	logic [15:0]             out_count_q;

	logic                    out_free;
	logic                    proc;

	// The byte in stage 1 is processed once the result slot is empty or being emptied.
	assign out_free   = !out_valid_q || result.ready;
	assign proc       = valid_s1 && out_free;
	assign text.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
		end
	end

	jaec_step u_step (
		.text_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jaec_pkg::SCAN_RESET;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	// Result slot: loaded by a byte that ends the scan, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && step_res.valid) begin
			out_status_q <= step_res.status;
			out_count_q  <= step_res.count;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.element_count = out_count_q;

	// Error results never carry a count.
	a_err_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != jaec_pkg::ST_OK |-> out_count_q == '0)
		else $error("error result with nonzero count");

	// Depth stays within the configured limit.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.depth <= jaec_pkg::DEPTH_W'(jaec_pkg::MAX_DEPTH))
		else $error("nesting depth beyond limit");

	// While draining, no byte produces a result.
	a_drain_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && state_q.phase == jaec_pkg::PH_DRAIN |-> !step_res.valid)
		else $error("result produced while draining");

	// A byte held back by a full result slot leaves the scanner state untouched.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> $stable(state_q))
		else $error("scanner state changed during stall");

endmodule
